>>> rtl/gregorian_date_add_days_macros.svh
// assertion macros shared by the date adder checkers
// no dependencies; included by the checker file
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define GDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define GDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gda_pkg.sv
// shared types, constants and calendar functions of the date adder
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package gda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ADD_W   = 14;
    localparam int TOTAL_W = 15;
    localparam int YLEN_W  = 9;
    localparam int REM_W   = 9;
    localparam int STEP_W  = 3;

    localparam int LEAP_CYCLE     = 400;
    localparam int CENTURY        = 100;
    localparam int YEAR_DAYS      = 365;
    localparam int LEAP_YEAR_DAYS = 366;
    localparam int FEB_LEAP_DAYS  = 29;
    localparam int MONTHS         = 12;
    localparam int FEBRUARY       = 2;
    // highest shift of the cycle length that still fits the year width
    localparam int MOD_STEPS_LAST = 5;

    localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mod_step;
        logic sum;
        logic year_step;
        logic month_step;
        logic out_load;
    } t_gda_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic mod_last;
        logic year_done;
        logic month_done;
        logic out_free;
    } t_gda_sts;

    // leap test from the low year bits and the year modulo 400
    function automatic logic leap_of(input logic [1:0] y_lo, input logic [REM_W-1:0] r400);
        logic [REM_W-1:0] r;
        r = r400;
        if (r >= REM_W'(2 * CENTURY)) r = r - REM_W'(2 * CENTURY);
        if (r >= REM_W'(CENTURY))     r = r - REM_W'(CENTURY);
        return ((y_lo == 2'd0) && (r != '0)) || (r400 == '0);
    endfunction

    function automatic logic [YLEN_W-1:0] year_len(input logic leap);
        return leap ? YLEN_W'(LEAP_YEAR_DAYS) : YLEN_W'(YEAR_DAYS);
    endfunction

    // days in month m; months outside one to twelve count as zero
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        if (m == '0 || m > MONTH_W'(MONTHS)) begin
            d = '0;
        end else if (m == MONTH_W'(FEBRUARY)) begin
            d = leap ? DAY_W'(FEB_LEAP_DAYS) : MONTH_LEN[1];
        end else begin
            d = MONTH_LEN[m - 4'd1];
        end
        return d;
    endfunction

    // days in the months before m, common year
    function automatic logic [YLEN_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [YLEN_W-1:0] d;
        unique case (m)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            4'd12:      d = 9'd334;
            default:    d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gregorian_date_add_days.sv
// Gregorian date adder, top level.
// Slave stream s_* carries one request: start date and a day count.
// Master stream m_* returns the date that many days later, one result per request.
// A request is taken when s_tvalid and s_tready are high at a clock edge;
// s_tready is high only while no request is in work.
// Steps per request, in order: the load, 6 reduction steps of the year modulo 400,
// the day-of-year sum, the year walk removing whole years (at most 45), the month
// walk (at most 11 months), the year and month end checks and the output load.
// The year walk removes one year per cycle through a single subtractor.
// The output register parts both sides: a new request is taken while a finished
// result still waits; only the next result's load waits for the output to drain.
// A stalled result holds its value and valid until m_tready is high.
// Synchronous active-low reset returns the controller to idle and drops m_tvalid.
// Depends on gda_pkg, gda_ctrl and gda_dpath.
`default_nettype none

module gregorian_date_add_days
    import gda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[36:23], zero pad
    input  wire logic [39:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // end_year[13:0], end_month[17:14], end_day[22:18], zero pad
    output logic [23:0]      o_m_tdata
);

    t_gda_cmd           cmd;
    t_gda_sts           sts;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;

    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gda_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_start_year  (i_s_tdata[13:0]),
        .i_start_month (i_s_tdata[17:14]),
        .i_start_day   (i_s_tdata[22:18]),
        .i_days_to_add (i_s_tdata[36:23]),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_end_year    (end_year),
        .o_end_month   (end_month),
        .o_end_day     (end_day)
    );

    // result packing, year in the lowest bits
    assign o_m_tdata = {1'b0, end_day, end_month, end_year};

endmodule

`default_nettype wire

>>> rtl/gda_ctrl.sv
// controller state machine of the date adder
// depends on gda_pkg for the command and status structs
`default_nettype none

module gda_ctrl
    import gda_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  t_gda_sts      i_sts,
    output t_gda_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_YEAR  = 3'd3;
    localparam logic [2:0] S_MONTH = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_YEAR;
            end
            S_YEAR: begin
                if (i_sts.year_done) begin
                    n_state = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_sts.month_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gda_dpath.sv
// datapath of the date adder: year reduction, year and month walks, output register
// depends on gda_pkg for widths, command/status structs and calendar functions
`default_nettype none

module gda_dpath
    import gda_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_gda_cmd                i_cmd,
    output t_gda_sts                o_sts,
    input  wire logic [YEAR_W-1:0]  i_start_year,
    input  wire logic [MONTH_W-1:0] i_start_month,
    input  wire logic [DAY_W-1:0]   i_start_day,
    input  wire logic [ADD_W-1:0]   i_days_to_add,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [YEAR_W-1:0]       o_end_year,
    output logic [MONTH_W-1:0]      o_end_month,
    output logic [DAY_W-1:0]        o_end_day
);

    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic [ADD_W-1:0]   r_add;
    logic [TOTAL_W-1:0] r_total;
    logic [YEAR_W-1:0]  r_rem;
    logic [STEP_W-1:0]  r_k;
    logic               r_out_valid;
    logic [YEAR_W-1:0]  r_out_year;
    logic [MONTH_W-1:0] r_out_month;
    logic [DAY_W-1:0]   r_out_day;

    logic               leap;
    logic [YLEN_W-1:0]  ylen;
    logic [DAY_W-1:0]   mdays;
    logic [YEAR_W-1:0]  mod_div;
    logic [REM_W-1:0]   rem_next;
    logic [TOTAL_W-1:0] doy;

    // leap flag of the current year, from the running remainder modulo 400
    assign leap    = leap_of(r_year[1:0], r_rem[REM_W-1:0]);
    assign ylen    = year_len(leap);
    assign mdays   = month_days(r_month, leap);
    assign mod_div = YEAR_W'(LEAP_CYCLE) << r_k;

    // day of year of the start date plus the day count
    assign doy = TOTAL_W'(days_before(r_month))
               + TOTAL_W'((r_month > MONTH_W'(FEBRUARY)) && leap)
               + TOTAL_W'(r_day) + TOTAL_W'(r_add);

    // remainder follows the year; the year wraps to zero at its top
    always_comb begin
        if (r_year == {YEAR_W{1'b1}} || r_rem[REM_W-1:0] == REM_W'(LEAP_CYCLE - 1)) begin
            rem_next = '0;
        end else begin
            rem_next = r_rem[REM_W-1:0] + REM_W'(1);
        end
    end

    assign o_sts.mod_last   = (r_k == '0);
    assign o_sts.year_done  = !(r_total > TOTAL_W'(ylen));
    assign o_sts.month_done = !((r_month < MONTH_W'(MONTHS)) && (r_total > TOTAL_W'(mdays)));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= i_start_year;
            r_month <= i_start_month;
            r_day   <= i_start_day;
            r_add   <= i_days_to_add;
            r_rem   <= i_start_year;
            r_k     <= STEP_W'(MOD_STEPS_LAST);
        end
        // one restoring step of year modulo 400
        if (i_cmd.mod_step) begin
            if (r_rem >= mod_div) r_rem <= r_rem - mod_div;
            r_k <= r_k - STEP_W'(1);
        end
        if (i_cmd.sum) begin
            r_total <= doy;
            r_month <= MONTH_W'(1);
        end
        // drop one whole year
        if (i_cmd.year_step) begin
            r_total <= r_total - TOTAL_W'(ylen);
            r_year  <= r_year + YEAR_W'(1);
            r_rem   <= YEAR_W'(rem_next);
        end
        // drop one whole month
        if (i_cmd.month_step) begin
            r_total <= r_total - TOTAL_W'(mdays);
            r_month <= r_month + MONTH_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_year  <= r_year;
            r_out_month <= r_month;
            r_out_day   <= r_total[DAY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_end_year  = r_out_year;
    assign o_end_month = r_out_month;
    assign o_end_day   = r_out_day;

endmodule

`default_nettype wire

>>> rtl/gda_checker.sv
// port-level checker of the date adder, bound to the top level
// depends on gregorian_date_add_days_macros.svh
`default_nettype none

`include "gregorian_date_add_days_macros.svh"

module gda_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata
);

    // a stalled result keeps valid and its value
    `GDA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "result valid dropped while stalled")
    `GDA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata), "result changed while stalled")
    // an accepted request blocks the input in the next cycle
    `GDA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input ready right after a request")
    // month walk always ends in one to twelve
    `GDA_ASSERT_NOW(a_month_range, i_clk, i_rst_n, o_m_tvalid, (o_m_tdata[17:14] != 4'd0) && (o_m_tdata[17:14] <= 4'd12), "result month out of range")

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (.*);

`default_nettype wire
